### src/protocol_line_byte_validator_macros.svh
// Assertion macros for the line byte validator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PROTOCOL_LINE_BYTE_VALIDATOR_MACROS_SVH
`define PROTOCOL_LINE_BYTE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLBV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLBV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/plbv_pkg.sv
// Types and constants for the line byte validator.
// Used by plbv_step, protocol_line_byte_validator and its testbench; depends on nothing.
package plbv_pkg;

	localparam int CP_W = 21;

	localparam logic [1:0] FAULT_NONE    = 2'd0;
	localparam logic [1:0] FAULT_UTF8    = 2'd1;
	localparam logic [1:0] FAULT_ESCAPE  = 2'd2;
	localparam logic [1:0] FAULT_CONTROL = 2'd3;

	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_S         = 8'h73;
	localparam logic [7:0] CHAR_N         = 8'h6E;
	localparam logic [7:0] CHAR_DEL       = 8'h7F;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam logic [CP_W-1:0] MIN_2BYTE = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3BYTE = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4BYTE = 21'h010000;
	localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_line;
	} line_item_t;

	typedef struct packed {
		logic       line_ok;
		logic [1:0] fault_kind;
	} verdict_t;

	typedef struct packed {
		logic [1:0]      expect_cnt;
		logic [1:0]      seq_len;
		logic [CP_W-1:0] cp;
		logic            utf8_bad;
		logic            bs_pend;
		logic            esc_bad;
		logic            ctrl_seen;
	} line_state_t;

endpackage

### src/plbv_step.sv
// Per-byte check logic: next line state and the verdict for a last byte.
// Depends on plbv_pkg.
module plbv_step import plbv_pkg::*; (
	input  line_state_t cur,
	input  line_item_t  item,
	output line_state_t nxt,
	output verdict_t    verdict
);

	line_state_t     upd;
	logic [7:0]      b;
	logic [CP_W-1:0] cp_ext;
	logic            range_bad;
	logic            utf8_fail;
	logic            esc_fail;

	assign b      = item.data_byte;
	assign cp_ext = {cur.cp[CP_W-7:0], b[5:0]};

	always_comb begin
		range_bad = ((cur.seq_len == 2'd1) && (cp_ext < MIN_2BYTE)) ||
			((cur.seq_len == 2'd2) && (cp_ext < MIN_3BYTE)) ||
			((cur.seq_len == 2'd3) && (cp_ext < MIN_4BYTE)) ||
			(cp_ext > MAX_CP) ||
			((cp_ext >= SURR_LO) && (cp_ext <= SURR_HI));
	end

	always_comb begin
		upd = cur;
		if (!cur.utf8_bad) begin
			if (cur.expect_cnt == 2'd0) begin
				if (!b[7]) begin
					upd.expect_cnt = 2'd0;
				end else if (b[7:5] == 3'b110) begin
					upd.expect_cnt = 2'd1;
					upd.seq_len    = 2'd1;
					upd.cp         = {{(CP_W-5){1'b0}}, b[4:0]};
				end else if (b[7:4] == 4'b1110) begin
					upd.expect_cnt = 2'd2;
					upd.seq_len    = 2'd2;
					upd.cp         = {{(CP_W-4){1'b0}}, b[3:0]};
				end else if (b[7:3] == 5'b11110) begin
					upd.expect_cnt = 2'd3;
					upd.seq_len    = 2'd3;
					upd.cp         = {{(CP_W-3){1'b0}}, b[2:0]};
				end else begin
					upd.utf8_bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				upd.utf8_bad = 1'b1;
			end else begin
				upd.cp         = cp_ext;
				upd.expect_cnt = cur.expect_cnt - 2'd1;
				// sequence complete: check overlong, range and surrogates
				if (cur.expect_cnt == 2'd1) begin
					upd.utf8_bad = range_bad;
					upd.seq_len  = 2'd0;
					upd.cp       = '0;
				end
			end
		end

		if (cur.bs_pend) begin
			if ((b != CHAR_S) && (b != CHAR_N) && (b != CHAR_BACKSLASH))
				upd.esc_bad = 1'b1;
			upd.bs_pend = 1'b0;
		end else if (b == CHAR_BACKSLASH) begin
			upd.bs_pend = 1'b1;
		end

		if ((b < CHAR_SPACE) || (b == CHAR_DEL))
			upd.ctrl_seen = 1'b1;
	end

	assign utf8_fail = upd.utf8_bad || (upd.expect_cnt != 2'd0);
	assign esc_fail  = upd.esc_bad || upd.bs_pend;

	always_comb begin
		if (utf8_fail)
			verdict.fault_kind = FAULT_UTF8;
		else if (esc_fail)
			verdict.fault_kind = FAULT_ESCAPE;
		else if (upd.ctrl_seen)
			verdict.fault_kind = FAULT_CONTROL;
		else
			verdict.fault_kind = FAULT_NONE;
		verdict.line_ok = (verdict.fault_kind == FAULT_NONE);
	end

	// clear for the next line after the last byte
	assign nxt = item.end_of_line ? '0 : upd;

endmodule

### src/protocol_line_byte_validator.sv
// Channel  | Direction | Handshake               | Payload
// line     | in        | line_valid / line_stall | line_item (data_byte, end_of_line)
// verdict  | out       | verdict_valid / verdict_stall | verdict (line_ok, fault_kind)
//
// One byte per cycle sustained while line_stall is low.
// The input register feeds the per-byte checks, which update the line state and
// load the verdict register on the last byte of a line.
// Reset clears the line state and both valid flags.
// line_stall rises only while a last byte waits on a full, stalled verdict register.
// Depends on plbv_pkg, plbv_step and protocol_line_byte_validator_macros.svh.
`include "protocol_line_byte_validator_macros.svh"

module protocol_line_byte_validator import plbv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	output logic       line_stall,
	input  line_item_t line_item,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output verdict_t   verdict
);

	line_item_t  item_s1;
	logic        valid_s1;
	line_state_t state_q;
	line_state_t state_nxt;
	verdict_t    verdict_nxt;
	verdict_t    verdict_q;
	logic        out_valid_q;
	logic        out_free;
	logic        advance_s1;
	logic        load_out;
	logic        accept;

	plbv_step u_step (
		.cur     (state_q),
		.item    (item_s1),
		.nxt     (state_nxt),
		.verdict (verdict_nxt)
	);

	assign out_free   = !out_valid_q || !verdict_stall;
	assign advance_s1 = valid_s1 && (!item_s1.end_of_line || out_free);
	assign load_out   = advance_s1 && item_s1.end_of_line;
	assign line_stall = valid_s1 && !advance_s1;
	assign accept     = line_valid && !line_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= line_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the verdict while stalled
	always_ff @(posedge clk) begin
		if (load_out)
			verdict_q <= verdict_nxt;
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = verdict_q;

	`PLBV_ASSERT_NOW(a_load_only_free, load_out, !out_valid_q || !verdict_stall,
		"verdict overwritten while stalled")
	`PLBV_ASSERT_NEXT(a_clear_after_line, load_out, state_q == '0,
		"line state not cleared after last byte")
	`PLBV_ASSERT_NOW(a_stall_cause, line_stall,
		valid_s1 && item_s1.end_of_line && out_valid_q && verdict_stall,
		"input stalled without a blocked verdict")
	`PLBV_ASSERT_NOW(a_ok_matches_kind, verdict_valid,
		verdict.line_ok == (verdict.fault_kind == FAULT_NONE),
		"line_ok disagrees with fault_kind")

endmodule

### sim/protocol_line_byte_validator_tb.sv
// Testbench for protocol_line_byte_validator: drives text lines byte by byte and checks
// each end-of-line verdict against a built-in UTF-8 / escape / control-byte predictor.
// Depends on plbv_pkg and the protocol_line_byte_validator RTL.
`timescale 1ns / 1ps

module protocol_line_byte_validator_tb import plbv_pkg::*;;

	localparam int LINE_BYTES  = 550;
	localparam int CALM_TAIL   = 40;
	localparam int STALL_LIMIT = 1000;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       line_valid    = 1'b0;
	logic       line_stall;
	line_item_t line_item     = '0;
	logic       verdict_valid;
	logic       verdict_stall = 1'b0;
	verdict_t   verdict;

	line_item_t byte_q[$];
	verdict_t   verdict_q[$];
	logic [7:0] line_buf[$];

	// predictor state for the line in progress
	logic [1:0]  owed_cont = '0;
	logic [1:0]  seq_cont  = '0;
	logic [20:0] cp_acc    = '0;
	logic        utf8_bad  = 1'b0;
	logic        bs_open   = 1'b0;
	logic        esc_bad   = 1'b0;
	logic        ctrl_hit  = 1'b0;

	int fail_cnt   = 0;
	int gap_left   = 0;
	int gap_pct    = 20;
	int stall_left = 0;
	int stall_pct  = 20;
	int idle_run   = 0;

	protocol_line_byte_validator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_valid    (line_valid),
		.line_stall    (line_stall),
		.line_item     (line_item),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 20;
			default: return 50;
		endcase
	endfunction

	// Fold one accepted byte into the line state; queue a verdict on the last byte.
	task automatic absorb_byte(input line_item_t it);
		logic [7:0] c;
		verdict_t   v;
		c = it.data_byte;
		if (!utf8_bad) begin
			if (owed_cont == 2'd0) begin
				if (!c[7]) begin
				end else if (c[7:5] == 3'b110) begin
					owed_cont = 2'd1;
					cp_acc    = {16'd0, c[4:0]};
				end else if (c[7:4] == 4'b1110) begin
					owed_cont = 2'd2;
					cp_acc    = {17'd0, c[3:0]};
				end else if (c[7:3] == 5'b11110) begin
					owed_cont = 2'd3;
					cp_acc    = {18'd0, c[2:0]};
				end else begin
					utf8_bad = 1'b1;
				end
				seq_cont = owed_cont;
			end else if (c[7:6] != 2'b10) begin
				utf8_bad = 1'b1;
			end else begin
				cp_acc    = {cp_acc[14:0], c[5:0]};
				owed_cont = owed_cont - 2'd1;
				if (owed_cont == 2'd0) begin
					// reject overlong forms, surrogates and out-of-range values
					if ((seq_cont == 2'd1 && cp_acc < MIN_2BYTE) ||
					    (seq_cont == 2'd2 && cp_acc < MIN_3BYTE) ||
					    (seq_cont == 2'd3 && cp_acc < MIN_4BYTE) ||
					    cp_acc > MAX_CP ||
					    (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
						utf8_bad = 1'b1;
					seq_cont = 2'd0;
					cp_acc   = '0;
				end
			end
		end

		if (bs_open) begin
			if (c != CHAR_S && c != CHAR_N && c != CHAR_BACKSLASH)
				esc_bad = 1'b1;
			bs_open = 1'b0;
		end else if (c == CHAR_BACKSLASH) begin
			bs_open = 1'b1;
		end

		if (c < CHAR_SPACE || c == CHAR_DEL)
			ctrl_hit = 1'b1;

		if (it.end_of_line) begin
			if (owed_cont != 2'd0)
				utf8_bad = 1'b1;
			if (bs_open)
				esc_bad = 1'b1;
			if (utf8_bad)
				v.fault_kind = FAULT_UTF8;
			else if (esc_bad)
				v.fault_kind = FAULT_ESCAPE;
			else if (ctrl_hit)
				v.fault_kind = FAULT_CONTROL;
			else
				v.fault_kind = FAULT_NONE;
			v.line_ok = (v.fault_kind == FAULT_NONE);
			verdict_q = {verdict_q, v};
			owed_cont = '0;
			seq_cont  = '0;
			cp_acc    = '0;
			utf8_bad  = 1'b0;
			bs_open   = 1'b0;
			esc_bad   = 1'b0;
			ctrl_hit  = 1'b0;
		end
	endtask

	// Move the buffered line into the byte queue, marking its last byte.
	task automatic flush_line();
		line_item_t it;
		foreach (line_buf[i]) begin
			it.data_byte   = line_buf[i];
			it.end_of_line = (i == line_buf.size() - 1);
			byte_q = {byte_q, it};
		end
		line_buf.delete();
	endtask

	// Append one byte to the line being built.
	task automatic put_byte(input logic [7:0] b);
		line_buf = {line_buf, b};
	endtask

	task automatic put_codepoint(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endtask

	// Append one token: mostly well-formed text, with broken forms unless clean.
	task automatic add_token(input bit clean);
		logic [7:0]  b;
		logic [20:0] cp;
		int          r;
		r = $urandom_range(clean ? 81 : 99);
		if (r < 35) begin
			b = 8'($urandom_range(32, 126));
			put_byte(b);
			if (b == CHAR_BACKSLASH)
				put_byte(CHAR_S);
		end else if (r < 45) begin
			put_byte(CHAR_BACKSLASH);
			case ($urandom_range(2))
				0: put_byte(CHAR_S);
				1: put_byte(CHAR_N);
				default: put_byte(CHAR_BACKSLASH);
			endcase
		end else if (r < 60) begin
			put_codepoint(21'($urandom_range(32'h80, 32'h7FF)));
		end else if (r < 72) begin
			cp = 21'($urandom_range(32'h800, 32'hFFFF));
			if (cp >= SURR_LO && cp <= SURR_HI)
				cp = cp ^ 21'h2000;
			put_codepoint(cp);
		end else if (r < 82) begin
			put_codepoint(21'($urandom_range(32'h10000, 32'h10FFFF)));
		end else begin
			case ($urandom_range(7))
				0: put_byte(8'($urandom_range(255)));
				1: put_byte($urandom_range(1) ? CHAR_DEL : 8'($urandom_range(31)));
				2: begin
					put_byte(CHAR_BACKSLASH);
					put_byte(8'($urandom_range(255)));
				end
				3: begin
					put_byte(8'hC0 | 8'($urandom_range(1)));
					put_byte({2'b10, 6'($urandom_range(63))});
				end
				4: put_codepoint(21'($urandom_range(32'hD800, 32'hDFFF)));
				5: put_codepoint(21'($urandom_range(32'h110000, 32'h1FFFFF)));
				6: put_byte(8'($urandom_range(8'hC2, 8'hF4)));
				default: put_byte(CHAR_BACKSLASH);
			endcase
		end
	endtask

	// Sender: accept, predict, then present the next byte or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			line_valid <= 1'b0;
		end else begin
			if (line_valid && !line_stall)
				absorb_byte(line_item);
			if ($urandom_range(63) == 0)
				gap_pct = pick_pct();
			// hold the item while it is stalled
			if (!(line_valid && line_stall)) begin
				if (gap_left == 0 && byte_q.size() >= CALM_TAIL && $urandom_range(99) < gap_pct)
					gap_left = $urandom_range(5, 1);
				if (gap_left != 0 || byte_q.size() == 0) begin
					line_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					line_valid <= 1'b1;
					line_item  <= byte_q.pop_front();
				end
			end
		end
	end

	// Receiver: check each accepted verdict and stall in random bursts.
	always @(posedge clk) begin
		verdict_t exp_v;
		if (!arst_n) begin
			verdict_stall <= 1'b0;
		end else begin
			if (verdict_valid && !verdict_stall) begin
				if (verdict_q.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected verdict: ok=%0d kind=%0d",
						         verdict.line_ok, verdict.fault_kind);
					fail_cnt++;
				end else begin
					exp_v = verdict_q.pop_front();
					if (verdict.line_ok !== exp_v.line_ok ||
					    verdict.fault_kind !== exp_v.fault_kind) begin
						if (fail_cnt < 10)
							$display("verdict mismatch: expected ok=%0d kind=%0d, got ok=%0d kind=%0d",
							         exp_v.line_ok, exp_v.fault_kind,
							         verdict.line_ok, verdict.fault_kind);
						fail_cnt++;
					end
				end
			end
			if ($urandom_range(63) == 0)
				stall_pct = pick_pct();
			if (stall_left == 0 && byte_q.size() >= CALM_TAIL && $urandom_range(99) < stall_pct)
				stall_left = $urandom_range(5, 1);
			if (stall_left != 0) begin
				verdict_stall <= 1'b1;
				stall_left--;
			end else begin
				verdict_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((line_valid && !line_stall) || (verdict_valid && !verdict_stall))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		// directed lines: extremes and the special cases
		line_buf = {8'h41};                      flush_line();
		line_buf = {8'h00};                      flush_line();
		line_buf = {8'hFF};                      flush_line();
		line_buf = {8'hC3};                      flush_line();  // sequence cut at end of line
		line_buf = {8'h5C};                      flush_line();  // trailing backslash
		line_buf = {8'h80, 8'h5C, 8'h78};        flush_line();  // UTF-8 fault outranks escape
		line_buf = {8'hF5, 8'h80, 8'h80, 8'h80}; flush_line();  // above range
		line_buf = {8'hED, 8'hA0, 8'h80};        flush_line();  // surrogate
		line_buf = {8'hC0, 8'h80};               flush_line();  // overlong
		line_buf = {8'h5C, 8'h73, 8'h7F};        flush_line();  // escape ok, DEL present
		line_buf = {8'hF4, 8'h8F, 8'hBF, 8'hBF}; flush_line();  // highest legal code point

		while (byte_q.size() < LINE_BYTES) begin
			automatic bit clean = ($urandom_range(9) < 6);
			automatic int n_tok = $urandom_range(10, 1);
			repeat (n_tok)
				add_token(clean);
			flush_line();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (byte_q.size() != 0 || line_valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
